FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

FILE: hw/rtl/dfsamw_pkg.sv
// ----------------------------------------------------------------------------
// dfsamw_pkg
// shared constants for the depth-first walk over an adjacency bit matrix
// ----------------------------------------------------------------------------
package dfsamw_pkg;

	// default node count of the graph
	localparam int NODES_DEF = 16;

	// width of a node field on the streams
	localparam int NODE_W = 4;

	// stream payload widths, whole bytes
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 8;

	// operation codes carried in s_tuser
	localparam logic OP_ADD_EDGE = 1'b0;
	localparam logic OP_SEARCH   = 1'b1;

endpackage

FILE: hw/rtl/dfsamw_ram.sv
// ----------------------------------------------------------------------------
// dfsamw_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module dfsamw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/dfs_adjacency_matrix_walk.sv
// an add-edge item keeps the input busy while it reads and writes both endpoint rows
// and gives no result; a search item pops each visited node, reads its row, scans
// the row with the one-neighbor-per-cycle scan and emits the node;
// a result stalled at the output adds its wait to the emit step of that node
// throughput: one item at a time. reset: asynchronous, active low; matrix rows
// read as empty through row valid flops, so no clearing pass is needed
// ----------------------------------------------------------------------------
// dfs_adjacency_matrix_walk
// undirected graph in an adjacency bit matrix with a stack-based depth-first
// walk; visited nodes stream out in pop order, the last one flagged by tlast
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dfs_adjacency_matrix_walk #(
	parameter int NODES = dfsamw_pkg::NODES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input items
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [3:0] first_node, [7:4] second_node
	input  logic [dfsamw_pkg::IN_DATA_W-1:0]  s_tdata,
	// [0] operation
	input  logic [0:0]                        s_tuser,
	// result items
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [3:0] visited_node, [7:4] zero
	output logic [dfsamw_pkg::OUT_DATA_W-1:0] m_tdata,
	// last_of_walk
	output logic                              m_tlast
);

	import dfsamw_pkg::*;

	// node index width, stack depth width, common width for field conversion
	localparam int NW = $clog2(NODES);
	localparam int DW = $clog2(NODES + 1);
	localparam int XW = (NW > NODE_W) ? NW : NODE_W;

	localparam logic [7:0]       NODES_L  = 8'(NODES);
	localparam logic [NW-1:0]    LAST_IDX = NW'(NODES - 1);
	localparam logic [NODES-1:0] ONE      = NODES'(1);

	// sequencer states
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_E_RA   = 4'd1; // read row of first endpoint
	localparam logic [3:0] ST_E_WA   = 4'd2; // write first row, read second
	localparam logic [3:0] ST_E_WB   = 4'd3; // write second row
	localparam logic [3:0] ST_P_RD   = 4'd4; // read stack top, pop
	localparam logic [3:0] ST_P_ROW  = 4'd5; // read adjacency row of popped node
	localparam logic [3:0] ST_P_LOAD = 4'd6; // latch the row for scanning
	localparam logic [3:0] ST_P_SCAN = 4'd7; // one neighbor per cycle, high to low
	localparam logic [3:0] ST_P_EMIT = 4'd8; // hand popped node to output register

	logic [3:0]       state_q;
	logic [DW-1:0]    depth_q;
	logic [NODES-1:0] visited_q;
	logic [NODES-1:0] row_vld_q;
	logic             rd_vld_q;
	logic [NW-1:0]    j_q;
	logic [NW-1:0]    a_q;
	logic [NW-1:0]    b_q;
	logic [NW-1:0]    cur_q;
	logic [NODES-1:0] row_q;
	logic             out_valid_q;
	logic [NODE_W-1:0] out_node_q;
	logic             out_last_q;

	// input decode
	logic [NODE_W-1:0] in_first;
	logic [NODE_W-1:0] in_second;
	logic              in_op;
	logic [XW-1:0]     first_ext;
	logic [XW-1:0]     second_ext;
	logic [NW-1:0]     first_idx;
	logic [NW-1:0]     second_idx;
	logic              first_ok;
	logic              second_ok;
	logic              accept;

	assign in_first   = s_tdata[NODE_W-1:0];
	assign in_second  = s_tdata[2*NODE_W-1:NODE_W];
	assign in_op      = s_tuser[0];
	assign first_ext  = XW'(in_first);
	assign second_ext = XW'(in_second);
	assign first_idx  = first_ext[NW-1:0];
	assign second_idx = second_ext[NW-1:0];
	// endpoints at or above the node count are dropped
	assign first_ok   = (8'(in_first) < NODES_L);
	assign second_ok  = (8'(in_second) < NODES_L);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// ram ports
	logic             adj_we;
	logic [NW-1:0]    adj_waddr;
	logic [NODES-1:0] adj_wdata;
	logic [NW-1:0]    adj_raddr;
	logic [NODES-1:0] adj_rdata;
	logic [NODES-1:0] row_now;

	logic             stk_we;
	logic [NW-1:0]    stk_waddr;
	logic [NW-1:0]    stk_wdata;
	logic [NW-1:0]    stk_raddr;
	logic [NW-1:0]    stk_rdata;

	logic [DW-1:0]    depth_m1;
	logic             scan_push;
	logic             out_free;
	logic             out_load;
	logic [XW-1:0]    cur_ext;

	// a row never written since reset reads as no edges
	assign row_now   = rd_vld_q ? adj_rdata : '0;
	assign depth_m1  = depth_q - DW'(1);
	assign stk_raddr = depth_m1[NW-1:0];
	// push a neighbor that is connected and not yet marked
	assign scan_push = row_q[j_q] && !visited_q[j_q];
	assign out_free  = !out_valid_q || m_tready;
	assign out_load  = (state_q == ST_P_EMIT) && out_free;
	assign cur_ext   = XW'(cur_q);

	always_comb begin
		adj_we    = 1'b0;
		adj_waddr = a_q;
		adj_wdata = row_now | (ONE << b_q);
		adj_raddr = a_q;
		stk_we    = 1'b0;
		stk_waddr = depth_q[NW-1:0];
		stk_wdata = j_q;
		case (state_q)
			ST_IDLE: begin
				// start node goes to the bottom of the stack
				stk_we    = accept && (in_op == OP_SEARCH) && first_ok;
				stk_waddr = '0;
				stk_wdata = first_idx;
			end
			ST_E_WA: begin
				adj_we    = 1'b1;
				adj_raddr = b_q;
			end
			ST_E_WB: begin
				// a self loop reads the old row here, so the result is the same
				adj_we    = 1'b1;
				adj_waddr = b_q;
				adj_wdata = row_now | (ONE << a_q);
			end
			ST_P_ROW: begin
				adj_raddr = stk_rdata;
			end
			ST_P_SCAN: begin
				stk_we = scan_push;
			end
			default: begin
			end
		endcase
	end

	dfsamw_ram #(
		.WIDTH (NODES),
		.DEPTH (NODES)
	) u_adj_ram (
		.clk   (clk),
		.we    (adj_we),
		.waddr (adj_waddr),
		.wdata (adj_wdata),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	dfsamw_ram #(
		.WIDTH (NW),
		.DEPTH (NODES)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			depth_q     <= '0;
			visited_q   <= '0;
			row_vld_q   <= '0;
			rd_vld_q    <= 1'b0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// row valid travels with the registered ram read
			rd_vld_q <= row_vld_q[adj_raddr];
			if (adj_we) begin
				row_vld_q[adj_waddr] <= 1'b1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_op == OP_ADD_EDGE) begin
							if (first_ok && second_ok) begin
								state_q <= ST_E_RA;
							end
						end else begin
							// fresh visited set; start node marked on push
							visited_q <= first_ok ? (ONE << first_idx) : '0;
							depth_q   <= first_ok ? DW'(1) : '0;
							if (first_ok) begin
								state_q <= ST_P_RD;
							end
						end
					end
				end
				ST_E_RA: state_q <= ST_E_WA;
				ST_E_WA: state_q <= ST_E_WB;
				ST_E_WB: state_q <= ST_IDLE;
				ST_P_RD: begin
					depth_q <= depth_m1;
					state_q <= ST_P_ROW;
				end
				ST_P_ROW: state_q <= ST_P_LOAD;
				ST_P_LOAD: begin
					j_q     <= LAST_IDX;
					state_q <= ST_P_SCAN;
				end
				ST_P_SCAN: begin
					if (scan_push) begin
						visited_q <= visited_q | (ONE << j_q);
						depth_q   <= depth_q + DW'(1);
					end
					if (j_q == '0) begin
						state_q <= ST_P_EMIT;
					end else begin
						j_q <= j_q - NW'(1);
					end
				end
				ST_P_EMIT: begin
					// empty stack after the scan means this was the last node
					if (out_free) begin
						state_q <= (depth_q == '0) ? ST_IDLE : ST_P_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			a_q <= first_idx;
			b_q <= second_idx;
		end
		if (state_q == ST_P_ROW) begin
			cur_q <= stk_rdata;
		end
		if (state_q == ST_P_LOAD) begin
			row_q <= row_now;
		end
		if (out_load) begin
			out_node_q <= cur_ext[NODE_W-1:0];
			out_last_q <= (depth_q == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'(out_node_q);
	assign m_tlast  = out_last_q;

	// stack is empty whenever a new item can be taken
	`ASSERT_PROP(a_idle_stack_empty, clk, arst_n, s_tready |-> (depth_q == '0))
	// each node is pushed once, so the stack never passes the node count
	`ASSERT_NEVER(a_depth_bound, clk, arst_n, depth_q > DW'(NODES))
	// entries on the stack are a subset of the marked nodes
	`ASSERT_PROP(a_marks_cover_stack, clk, arst_n,
		(state_q != ST_IDLE) |-> ($countones(visited_q) >= int'(depth_q)))
	// a result flagged last ends the walk
	`ASSERT_PROP(a_last_ends_walk, clk, arst_n,
		(out_load && (depth_q == '0)) |=> (state_q == ST_IDLE))

endmodule
